@@ sv/message_slot_ring_buffer_defines.svh @@
// ----------------------------------------------------------------------------
// message_slot_ring_buffer_defines
// Assertion helpers for the message slot ring buffer. Both macros expect a
// signal named clk, and MSRB_CHECK one named rst, in the scope where used.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_SLOT_RING_BUFFER_DEFINES_SVH
`define MESSAGE_SLOT_RING_BUFFER_DEFINES_SVH

// Checked only while the block is out of reset.
`define MSRB_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, including during reset.
`define MSRB_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/msrb_pkg.sv @@
// ----------------------------------------------------------------------------
// msrb_pkg
// Shared types and constants for the message slot ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package msrb_pkg;

  localparam int OPCODE_W = 2;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 7;
  localparam int BCNT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RESET = 4'd8;
  localparam logic [LEN_W-1:0]  BLOCK_SIZE_RESET  = 7'd64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_NOBLK = 3'd2,
    ST_LONG  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_BLOCK_COUNT = 1'b0,
    REG_BLOCK_SIZE  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [BCNT_W-1:0] block_count;
    logic [LEN_W-1:0]  block_size;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/msrb_if.sv @@
// ----------------------------------------------------------------------------
// msrb_in_if / msrb_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface msrb_in_if #(
  parameter int DATA_WIDTH = 8
);
  logic                          valid;
  logic                          ready;
  logic [msrb_pkg::OPCODE_W-1:0] opcode;
  logic [DATA_WIDTH-1:0]         data_element;
  logic                          last_element;
  logic [msrb_pkg::IDX_W-1:0]    element_index;

  modport source (output valid, opcode, data_element, last_element, element_index,
                  input ready);
  modport sink   (input valid, opcode, data_element, last_element, element_index,
                  output ready);
endinterface

interface msrb_out_if #(
  parameter int DATA_WIDTH = 8
);
  logic                          valid;
  logic                          ready;
  logic [msrb_pkg::STATUS_W-1:0] status;
  logic [msrb_pkg::LEN_W-1:0]    block_length;
  logic [DATA_WIDTH-1:0]         read_data;

  modport source (output valid, status, block_length, read_data, input ready);
  modport sink   (input valid, status, block_length, read_data, output ready);
endinterface

`default_nettype wire

@@ sv/msrb_regs.sv @@
// ----------------------------------------------------------------------------
// msrb_regs
// APB configuration registers: block count and maximum block size.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [msrb_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [msrb_pkg::PDATA_W-1:0]     pwdata,
  output logic      [msrb_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready,
  output msrb_pkg::cfg_t                        cfg
);
  import msrb_pkg::*;

  reg_index_t reg_sel;
  logic       wr_en;

  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_count <= BLOCK_COUNT_RESET;
      cfg.block_size  <= BLOCK_SIZE_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BLOCK_COUNT: cfg.block_count <= pwdata[BCNT_W-1:0];
        REG_BLOCK_SIZE:  cfg.block_size  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_BLOCK_COUNT: prdata[BCNT_W-1:0] = cfg.block_count;
      REG_BLOCK_SIZE:  prdata[LEN_W-1:0]  = cfg.block_size;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/msrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// msrb_ctrl
// Two-state sequencer: take one item, then execute it once the result
// register can accept a new result.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire msrb_pkg::dp_status_t   dp_stat,
  output msrb_pkg::ctrl_cmd_t         cmd
);
  import msrb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/msrb_dp.sv @@
// ----------------------------------------------------------------------------
// msrb_dp
// Datapath: slot pointers, occupancy, length and block memories, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_dp #(
  parameter int SLOTS           = 8,
  parameter int MAX_BLOCK_WORDS = 64,
  parameter int DATA_WIDTH      = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msrb_pkg::cfg_t       cfg,
  input  wire msrb_pkg::ctrl_cmd_t  cmd,
  output msrb_pkg::dp_status_t      dp_stat,
  msrb_in_if.sink                   in_ch,
  msrb_out_if.source                out_ch
);
  import msrb_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DEPTH  = SLOTS * MAX_BLOCK_WORDS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAXW_W = $clog2(MAX_BLOCK_WORDS + 1);
  localparam int CMP_W  = (MAXW_W > LEN_W) ? MAXW_W : LEN_W;

  // Captured item.
  opcode_t               op_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic                  last_q;
  logic [IDX_W-1:0]      idx_q;

  // Memories and their registered read data.
  logic [LEN_W-1:0]      len_mem [SLOTS];
  logic [DATA_WIDTH-1:0] blk_mem [DEPTH];
  logic [LEN_W-1:0]      len_rd;
  logic [DATA_WIDTH-1:0] blk_rd;

  // Control state.
  logic [SLOTS-1:0]  occupied;
  logic [SLOTS-1:0]  occupied_next;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] read_slot;
  logic [SLOT_W-1:0] read_slot_next;
  logic [BCNT_W-1:0] blocks_in_use;
  logic [BCNT_W-1:0] blocks_in_use_next;
  logic [LEN_W-1:0]  fill_count;
  logic [LEN_W-1:0]  fill_count_next;
  logic              discard_flag;
  logic              discard_flag_next;

  // Result register.
  logic                  out_valid;
  status_t               out_status;
  logic [LEN_W-1:0]      out_length;
  logic [DATA_WIDTH-1:0] out_data;

  // Execute-stage results.
  status_t               res_status;
  logic [LEN_W-1:0]      res_length;
  logic [DATA_WIDTH-1:0] res_data;
  logic                  blk_we;
  logic                  len_we;
  logic [LEN_W-1:0]      fill_inc;
  logic                  too_long;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_addr = ADDR_W'(write_slot) * ADDR_W'(MAX_BLOCK_WORDS) + ADDR_W'(fill_count);
  assign rd_addr = ADDR_W'(read_slot) * ADDR_W'(MAX_BLOCK_WORDS)
                 + ADDR_W'(in_ch.element_index);
  assign fill_inc = fill_count + 1'b1;

  // An element beyond the lesser of block_size and the block capacity is too long.
  assign too_long = (fill_count >= cfg.block_size)
                 || (CMP_W'(fill_count) >= CMP_W'(MAX_BLOCK_WORDS));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode_t'(in_ch.opcode);
      data_q <= in_ch.data_element;
      last_q <= in_ch.last_element;
      idx_q  <= in_ch.element_index;
      len_rd <= len_mem[read_slot];
      blk_rd <= blk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[wr_addr] <= data_q;
    end
    if (len_we) begin
      len_mem[write_slot] <= fill_inc;
    end
  end

  always_comb begin
    res_status         = ST_OK;
    res_length         = '0;
    res_data           = '0;
    blk_we             = 1'b0;
    len_we             = 1'b0;
    occupied_next      = occupied;
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    blocks_in_use_next = blocks_in_use;
    fill_count_next    = fill_count;
    discard_flag_next  = discard_flag;
    case (op_q)
      OP_WRITE: begin
        if (discard_flag) begin
          if (last_q) begin
            discard_flag_next = 1'b0;
          end
        end else if ((fill_count == '0) && occupied[write_slot]) begin
          res_status        = ST_FULL;
          fill_count_next   = '0;
          discard_flag_next = !last_q;
        end else if ((fill_count == '0) && (blocks_in_use >= cfg.block_count)) begin
          res_status        = ST_NOBLK;
          fill_count_next   = '0;
          discard_flag_next = !last_q;
        end else if (too_long) begin
          res_status        = ST_LONG;
          fill_count_next   = '0;
          discard_flag_next = !last_q;
        end else begin
          blk_we          = 1'b1;
          fill_count_next = fill_inc;
          if (last_q) begin
            len_we                    = 1'b1;
            occupied_next[write_slot] = 1'b1;
            write_slot_next           = slot_inc(write_slot);
            blocks_in_use_next        = blocks_in_use + 1'b1;
            fill_count_next           = '0;
          end
        end
      end
      OP_READ: begin
        if (!occupied[read_slot]) begin
          res_status = ST_EMPTY;
        end else begin
          res_length = len_rd;
          if ({1'b0, idx_q} < len_rd) begin
            res_data = blk_rd;
          end
        end
      end
      OP_FREE: begin
        if (!occupied[read_slot]) begin
          res_status = ST_EMPTY;
        end else begin
          occupied_next[read_slot] = 1'b0;
          read_slot_next           = slot_inc(read_slot);
          if (blocks_in_use != '0) begin
            blocks_in_use_next = blocks_in_use - 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (!cmd.commit) begin
      blk_we = 1'b0;
      len_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied      <= '0;
      write_slot    <= '0;
      read_slot     <= '0;
      blocks_in_use <= '0;
      fill_count    <= '0;
      discard_flag  <= 1'b0;
    end else if (cmd.commit) begin
      occupied      <= occupied_next;
      write_slot    <= write_slot_next;
      read_slot     <= read_slot_next;
      blocks_in_use <= blocks_in_use_next;
      fill_count    <= fill_count_next;
      discard_flag  <= discard_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_length <= res_length;
      out_data   <= res_data;
    end
  end

  assign dp_stat.out_free    = !out_valid || out_ch.ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.block_length = out_length;
  assign out_ch.read_data    = out_data;

endmodule

`default_nettype wire

@@ sv/message_slot_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// message_slot_ring_buffer
// Ring of message slots with a stored length per slot and APB configuration.
// ----------------------------------------------------------------------------
// Items are taken one at a time: each is captured together with the memory
// reads, and executed once the result register can accept its result; the
// next item is taken only after that. The result is registered on execution.
// The result register lets the next item be taken while a result waits.
// Reset clears pointers, counters and slot occupancy at once; no clearing pass.
`default_nettype none

`include "message_slot_ring_buffer_defines.svh"

module message_slot_ring_buffer #(
  parameter int SLOTS           = 8,
  parameter int MAX_BLOCK_WORDS = 64,
  parameter int DATA_WIDTH      = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  msrb_in_if.sink                            in_ch,
  msrb_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msrb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [msrb_pkg::PDATA_W-1:0]  pwdata,
  output logic      [msrb_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import msrb_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;

  msrb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  msrb_dp #(
    .SLOTS           (SLOTS),
    .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS),
    .DATA_WIDTH      (DATA_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .dp_stat (dp_stat),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  `MSRB_CHECK(a_one_item_in_flight,
              in_ch.valid && in_ch.ready |=> !in_ch.ready,
              "item accepted while another is executing")
  `MSRB_CHECK(a_commit_has_room,
              cmd.commit |-> (!out_ch.valid || out_ch.ready),
              "result overwritten before transaction")
  `MSRB_CHECK(a_empty_has_no_length,
              out_ch.valid && (out_ch.status == ST_EMPTY) |-> (out_ch.block_length == '0),
              "empty status with nonzero length")
  `MSRB_CHECK_ALWAYS(a_reset_clears_out,
                     $past(rst) |-> !out_ch.valid,
                     "result valid right after reset")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the message slot ring buffer. A scoreboard
// class keeps its own copy of the slot ring and the register values, predicts
// the result of every request transaction, and compares each result
// transaction in order. A short directed sequence hits the slot-full,
// no-free-block, too-long, empty-queue and out-of-range read cases. Random
// messages, reads, frees and noise then run under eight register settings,
// with sender gaps, receiver stalls and long back-pressure holds.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import msrb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    status_t          st;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
  } msg_result_t;

  class msrb_scoreboard;
    logic [BCNT_W-1:0] blk_count;
    logic [LEN_W-1:0]  blk_size;
    logic [LEN_W-1:0]  slot_len [8];
    logic [7:0]        store [512];
    logic [2:0]        wr_ptr;
    logic [2:0]        rd_ptr;
    logic [3:0]        used;
    logic [LEN_W-1:0]  fill;
    bit                dropping;
    msg_result_t       expected_q [$];
    int unsigned       mismatches;
    int unsigned       results_checked;
    int unsigned       status_seen [5];

    function new();
      blk_count = BLOCK_COUNT_RESET;
      blk_size  = BLOCK_SIZE_RESET;
      foreach (slot_len[i]) slot_len[i] = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      used = '0;
      fill = '0;
      dropping = 1'b0;
      mismatches = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(reg_index_t r, logic [PDATA_W-1:0] value);
      if (r == REG_BLOCK_COUNT) blk_count = value[BCNT_W-1:0];
      else blk_size = value[LEN_W-1:0];
    endfunction

    function void drop_message(bit last);
      fill = '0;
      dropping = !last;
    endfunction

    function status_t predict_write(logic [7:0] data, bit last);
      int limit;
      limit = (blk_size > 64) ? 64 : int'(blk_size);
      if (dropping) begin
        if (last) dropping = 1'b0;
        return ST_OK;
      end
      if (fill == 0) begin
        if (slot_len[wr_ptr] != 0) begin
          drop_message(last);
          return ST_FULL;
        end
        if (used >= blk_count) begin
          drop_message(last);
          return ST_NOBLK;
        end
      end
      if (int'(fill) >= limit) begin
        drop_message(last);
        return ST_LONG;
      end
      store[{wr_ptr, fill[5:0]}] = data;
      fill++;
      if (last) begin
        slot_len[wr_ptr] = fill;
        wr_ptr++;
        used++;
        fill = '0;
      end
      return ST_OK;
    endfunction

    function void note_item(opcode_t op, logic [7:0] data, bit last, logic [IDX_W-1:0] idx);
      msg_result_t r;
      r = '{st: ST_OK, len: '0, data: '0};
      case (op)
        OP_WRITE: r.st = predict_write(data, last);
        OP_READ: begin
          if (slot_len[rd_ptr] == 0) begin
            r.st = ST_EMPTY;
          end else begin
            r.len = slot_len[rd_ptr];
            if (idx < slot_len[rd_ptr]) r.data = store[{rd_ptr, idx}];
          end
        end
        OP_FREE: begin
          if (slot_len[rd_ptr] == 0) begin
            r.st = ST_EMPTY;
          end else begin
            slot_len[rd_ptr] = '0;
            rd_ptr++;
            if (used > 0) used--;
          end
        end
        default: ;
      endcase
      status_seen[r.st]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [LEN_W-1:0] len,
                               logic [7:0] data);
      msg_result_t e;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: status %0d length %0d data %02h",
                   st, len, data);
        return;
      end
      e = expected_q.pop_front();
      if (e.st !== st || e.len !== len || e.data !== data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on result %0d: expected status %0d length %0d data %02h, got status %0d length %0d data %02h",
                   results_checked, e.st, e.len, e.data, st, len, data);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  msrb_in_if  #(.DATA_WIDTH(8)) in_ch ();
  msrb_out_if #(.DATA_WIDTH(8)) out_ch ();

  message_slot_ring_buffer DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  msrb_scoreboard sb = new();

  int idle_pct;
  int stall_pct;
  int hold_left;
  int items_sent;
  int settings_used;
  int unsigned cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: samples the transaction at each edge, then picks the next ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.block_length, out_ch.read_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input opcode_t op, input logic [7:0] data, input bit last,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.data_element  <= data;
    in_ch.last_element  <= last;
    in_ch.element_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, data, last, idx);
    items_sent++;
  endtask

  // Lowers valid and waits for every predicted result to come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input reg_index_t r, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, value);
  endtask

  task automatic configure(input logic [BCNT_W-1:0] bcount, input logic [LEN_W-1:0] bsize);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_BLOCK_COUNT, PDATA_W'(bcount));
    write_reg(REG_BLOCK_SIZE, PDATA_W'(bsize));
    settings_used++;
  endtask

  task automatic send_message(input int len);
    for (int k = 0; k < len; k++)
      send_item(OP_WRITE, 8'($urandom_range(0, 255)), k == len - 1,
                IDX_W'($urandom_range(0, 63)));
  endtask

  // One random step: mostly whole messages, reads and frees, with some noise.
  task automatic random_step();
    int r;
    int pick;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (r < 45) begin
      if (pick < 80) send_message($urandom_range(1, 8));
      else if (pick < 95) send_message($urandom_range(1, 70));
      else send_message($urandom_range(60, 68));
    end else if (r < 70) begin
      send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                (pick < 80) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom_range(0, 63)));
    end else if (r < 88) begin
      send_item(OP_FREE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                IDX_W'($urandom_range(0, 63)));
    end else begin
      send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    logic [BCNT_W-1:0] bc_table [8];
    logic [LEN_W-1:0]  bs_table [8];
    int phase_end;
    bc_table = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd2, 4'd8, 4'd5};
    bs_table = '{7'd64, 7'd1, 7'd6, 7'd127, 7'd12, 7'd0, 7'd65, 7'd9};
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    items_sent = 0;
    settings_used = 0;
    cycles = 0;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_NONE;
    in_ch.data_element  <= '0;
    in_ch.last_element  <= 1'b0;
    in_ch.element_index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the reset register values.
    send_item(OP_READ, 8'h00, 1'b0, 6'd0);
    send_item(OP_FREE, 8'hFF, 1'b1, 6'd63);
    send_item(OP_NONE, 8'hFF, 1'b1, 6'd63);
    send_item(OP_WRITE, 8'hFF, 1'b1, 6'd0);
    send_item(OP_READ, 8'h00, 1'b0, 6'd0);
    send_item(OP_READ, 8'h00, 1'b0, 6'd63);
    send_item(OP_WRITE, 8'h00, 1'b0, 6'd0);
    send_item(OP_WRITE, 8'hA5, 1'b0, 6'd0);
    send_item(OP_WRITE, 8'h5A, 1'b1, 6'd0);
    send_item(OP_FREE, 8'h00, 1'b0, 6'd0);
    send_item(OP_READ, 8'h00, 1'b0, 6'd2);
    // Fill every slot so that the next message finds its slot occupied.
    for (int k = 1; k <= 7; k++)
      send_item(OP_WRITE, 8'(k * 17), 1'b1, 6'd0);
    send_item(OP_WRITE, 8'h11, 1'b0, 6'd0);
    send_item(OP_WRITE, 8'h22, 1'b1, 6'd0);
    configure(4'd1, 7'd64);
    send_item(OP_FREE, 8'h00, 1'b0, 6'd0);
    send_item(OP_WRITE, 8'h33, 1'b1, 6'd0);
    configure(4'd8, 7'd1);
    send_item(OP_WRITE, 8'h44, 1'b0, 6'd0);
    send_item(OP_WRITE, 8'h55, 1'b1, 6'd0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) configure(4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
      else configure(bc_table[ph], bs_table[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      // Long hold on the result side while requests keep coming.
      if (ph == 0 || ph == 4) hold_left = 300;
      while (items_sent < phase_end) begin
        random_step();
        if (ph == 1 && items_sent >= phase_end - PHASE_ITEMS / 2 && sb.pending() != 0
            && $urandom_range(0, 9) == 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d request transactions under %0d register settings, with gaps, stalls and back-pressure holds.",
             items_sent, settings_used);
    $display("Result statuses: ok %0d, slot full %0d, no block %0d, too long %0d, empty %0d; %0d mismatches.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
